FILE: sv/triangle_elevation_lookup_assert.svh
// ----------------------------------------------------------------------------
// triangle elevation lookup assertion macros
// shared property forms for the lookup block
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_ELEVATION_LOOKUP_ASSERT_SVH
`define TRIANGLE_ELEVATION_LOOKUP_ASSERT_SVH

// same-cycle implication
`define TEL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tel assertion failed");

// next-cycle implication
`define TEL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tel assertion failed");

`endif

FILE: sv/tel_pkg.sv
// ----------------------------------------------------------------------------
// tel_pkg
// shared constants and sequencer states of the triangle elevation lookup
// ----------------------------------------------------------------------------
package tel_pkg;

   localparam int COORD_BITS_DEFAULT = 32;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_LOAD   = 8'b0000_0010,
      S_MUL    = 8'b0000_0100,
      S_AREA   = 8'b0000_1000,
      S_AABS   = 8'b0001_0000,
      S_NABS   = 8'b0010_0000,
      S_DIV    = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

endpackage

FILE: sv/tel_channel_if.sv
// ----------------------------------------------------------------------------
// tel channel interfaces
// triangle request and elevation response channels, valid/ready
// ----------------------------------------------------------------------------
interface tel_req_if #(parameter int COORD_BITS = tel_pkg::COORD_BITS_DEFAULT) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] query_x;
   logic [COORD_BITS-1:0] query_y;
   logic [COORD_BITS-1:0] vert_a_x;
   logic [COORD_BITS-1:0] vert_a_y;
   logic [COORD_BITS-1:0] vert_a_z;
   logic [COORD_BITS-1:0] vert_b_x;
   logic [COORD_BITS-1:0] vert_b_y;
   logic [COORD_BITS-1:0] vert_b_z;
   logic [COORD_BITS-1:0] vert_c_x;
   logic [COORD_BITS-1:0] vert_c_y;
   logic [COORD_BITS-1:0] vert_c_z;
   logic                  last_triangle;

   modport source (
      output valid, query_x, query_y, vert_a_x, vert_a_y, vert_a_z,
             vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
             last_triangle,
      input  ready
   );
   modport sink (
      input  valid, query_x, query_y, vert_a_x, vert_a_y, vert_a_z,
             vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
             last_triangle,
      output ready
   );
endinterface

interface tel_rsp_if #(parameter int COORD_BITS = tel_pkg::COORD_BITS_DEFAULT) ();
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [COORD_BITS-1:0] elevation;

   modport source (output valid, found, elevation, input ready);
   modport sink (input valid, found, elevation, output ready);
endinterface

FILE: sv/triangle_elevation_lookup.sv
// ----------------------------------------------------------------------------
// triangle elevation lookup
// barycentric point-in-triangle search over a triangle stream with
// interpolated elevation of the first containing triangle
// ----------------------------------------------------------------------------
//  channel  dir  payload                                     transaction
//  req      in   query x/y, vertices a/b/c x/y/z, last mark  one triangle
//  rsp      out  found, elevation                            one per last triangle
//
//  one shared add/subtract unit runs a sequencer: six shift-add products
//  for the edge weights, the area sum, three more products for the
//  numerator, then n restoring divide steps (n = COORD_BITS)
//  a triangle that misses or is degenerate skips the numerator and divide,
//  and one after a hit goes straight to the finish step
//  synchronous active-high reset clears sequencer, hit and response valid
//  a last triangle waits in the finish step while the response is stalled
`include "triangle_elevation_lookup_assert.svh"

module triangle_elevation_lookup #(
   parameter int COORD_BITS = tel_pkg::COORD_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   tel_req_if.sink   req,
   tel_rsp_if.source rsp
);

   localparam int N   = COORD_BITS;
   localparam int DW  = N + 1;
   localparam int WTW = 2 * N + 3;
   localparam int AW  = 2 * N + 5;
   localparam int W   = 3 * N + 6;
   localparam int CW  = $clog2(N + 1);

   tel_pkg::state_type state_ff, state_in;

   logic [N-1:0] qx_ff, qy_ff, ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic [N-1:0] cx_ff, cy_ff, cz_ff;
   logic [N-1:0] qx_in, qy_in, ax_in, ay_in, az_in, bx_in, by_in, bz_in;
   logic [N-1:0] cx_in, cy_in, cz_in;
   logic         last_ff, last_in;

   logic [W-1:0]   acc_ff, acc_in, mc_ff, mc_in;
   logic [DW-1:0]  mp_ff, mp_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [2:0]     k_ff, k_in;
   logic           phase_ff, phase_in;
   logic [WTW-1:0] wa_ff, wb_ff, wc_ff, wa_in, wb_in, wc_in;
   logic [AW-1:0]  area_ff, area_in;
   logic           qneg_ff, qneg_in;
   logic [N-1:0]   q_ff, q_in;
   logic           hit_ff, hit_in;
   logic [N-1:0]   held_ff, held_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           found_ff, found_in;
   logic [N-1:0]   elev_ff, elev_in;

   logic [DW-1:0] d_cbx, d_yby, d_cby, d_xbx, d_acx, d_ycy, d_acy, d_xcx;
   logic [DW-1:0] d_bax, d_yay, d_bay, d_xax;
   logic [DW-1:0] mc_sel, mp_sel;
   logic [WTW-1:0] w_sel;
   logic [N-1:0]  z_sel;

   logic         add_zero_a, add_sub;
   logic [W-1:0] add_a, add_b, add_sum, acc_mul, div_opnd;
   logic         mul_top, contain, area_zero;
   logic [N-1:0] q_fin;
   logic         rsp_free;

   function automatic logic [DW-1:0] sdiff(input logic [N-1:0] a, input logic [N-1:0] b);
      sdiff = {a[N-1], a} - {b[N-1], b};
   endfunction

   assign d_cbx = sdiff(cx_ff, bx_ff);
   assign d_yby = sdiff(qy_ff, by_ff);
   assign d_cby = sdiff(cy_ff, by_ff);
   assign d_xbx = sdiff(qx_ff, bx_ff);
   assign d_acx = sdiff(ax_ff, cx_ff);
   assign d_ycy = sdiff(qy_ff, cy_ff);
   assign d_acy = sdiff(ay_ff, cy_ff);
   assign d_xcx = sdiff(qx_ff, cx_ff);
   assign d_bax = sdiff(bx_ff, ax_ff);
   assign d_yay = sdiff(qy_ff, ay_ff);
   assign d_bay = sdiff(by_ff, ay_ff);
   assign d_xax = sdiff(qx_ff, ax_ff);

   always_comb begin
      case (k_ff)
         3'd0:    begin mc_sel = d_cbx; mp_sel = d_yby; end
         3'd1:    begin mc_sel = d_cby; mp_sel = d_xbx; end
         3'd2:    begin mc_sel = d_acx; mp_sel = d_ycy; end
         3'd3:    begin mc_sel = d_acy; mp_sel = d_xcx; end
         3'd4:    begin mc_sel = d_bax; mp_sel = d_yay; end
         default: begin mc_sel = d_bay; mp_sel = d_xax; end
      endcase
      case (k_ff)
         3'd0:    begin w_sel = wa_ff; z_sel = az_ff; end
         3'd1:    begin w_sel = wb_ff; z_sel = bz_ff; end
         default: begin w_sel = wc_ff; z_sel = cz_ff; end
      endcase
   end

   // shared adder
   assign add_a   = add_zero_a ? '0 : acc_ff;
   assign add_sum = add_a + (add_sub ? ~add_b : add_b) + W'(add_sub);

   assign mul_top   = (cnt_ff == CW'(N));
   assign acc_mul   = mp_ff[0] ? add_sum : acc_ff;
   assign div_opnd  = {{(W-AW){1'b0}}, area_ff} << cnt_ff;
   assign area_zero = (acc_ff == '0);
   assign contain   = (!wa_ff[WTW-1] && !wb_ff[WTW-1] && !wc_ff[WTW-1]) ||
                      ((wa_ff[WTW-1] || wa_ff == '0) && (wb_ff[WTW-1] || wb_ff == '0) &&
                       (wc_ff[WTW-1] || wc_ff == '0));
   assign q_fin     = {q_ff[N-2:0], ~add_sum[W-1]};
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   assign req.ready     = (state_ff == tel_pkg::S_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.found     = found_ff;
   assign rsp.elevation = elev_ff;

   always_comb begin
      state_in = state_ff;
      qx_in = qx_ff; qy_in = qy_ff;
      ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff;
      bx_in = bx_ff; by_in = by_ff; bz_in = bz_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      last_in = last_ff;
      acc_in = acc_ff; mc_in = mc_ff; mp_in = mp_ff; cnt_in = cnt_ff;
      k_in = k_ff; phase_in = phase_ff;
      wa_in = wa_ff; wb_in = wb_ff; wc_in = wc_ff;
      area_in = area_ff; qneg_in = qneg_ff; q_in = q_ff;
      hit_in = hit_ff; held_in = held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      found_in = found_ff; elev_in = elev_ff;
      add_zero_a = 1'b0;
      add_sub    = 1'b0;
      add_b      = mc_ff;

      case (state_ff)
         tel_pkg::S_IDLE: begin
            if (req.valid) begin
               qx_in = req.query_x;  qy_in = req.query_y;
               ax_in = req.vert_a_x; ay_in = req.vert_a_y; az_in = req.vert_a_z;
               bx_in = req.vert_b_x; by_in = req.vert_b_y; bz_in = req.vert_b_z;
               cx_in = req.vert_c_x; cy_in = req.vert_c_y; cz_in = req.vert_c_z;
               last_in  = req.last_triangle;
               acc_in   = '0;
               k_in     = '0;
               phase_in = 1'b0;
               state_in = hit_ff ? tel_pkg::S_FINISH : tel_pkg::S_LOAD;
            end
         end
         tel_pkg::S_LOAD: begin
            if (!phase_ff) begin
               mc_in = {{(W-DW){mc_sel[DW-1]}}, mc_sel};
               mp_in = mp_sel;
            end else begin
               mc_in = {{(W-WTW){w_sel[WTW-1]}}, w_sel};
               mp_in = {z_sel[N-1], z_sel};
            end
            cnt_in   = '0;
            state_in = tel_pkg::S_MUL;
         end
         tel_pkg::S_MUL: begin
            // sign bit of the multiplier has negative weight
            add_sub = (!phase_ff && k_ff[0]) ^ mul_top;
            acc_in  = acc_mul;
            mc_in   = mc_ff << 1;
            mp_in   = mp_ff >> 1;
            cnt_in  = cnt_ff + CW'(1);
            if (mul_top) begin
               cnt_in = '0;
               k_in   = k_ff + 3'd1;
               state_in = tel_pkg::S_LOAD;
               if (!phase_ff) begin
                  if (k_ff[0]) begin
                     acc_in = '0;
                     case (k_ff[2:1])
                        2'd0:    wa_in = acc_mul[WTW-1:0];
                        2'd1:    wb_in = acc_mul[WTW-1:0];
                        default: wc_in = acc_mul[WTW-1:0];
                     endcase
                  end
                  if (k_ff == 3'd5) begin
                     k_in     = '0;
                     state_in = tel_pkg::S_AREA;
                  end
               end else if (k_ff == 3'd2) begin
                  state_in = tel_pkg::S_NABS;
               end
            end
         end
         tel_pkg::S_AREA: begin
            add_b  = {{(W-WTW){w_sel[WTW-1]}}, w_sel};
            acc_in = add_sum;
            k_in   = k_ff + 3'd1;
            if (k_ff == 3'd2) begin
               state_in = tel_pkg::S_AABS;
            end
         end
         tel_pkg::S_AABS: begin
            add_zero_a = 1'b1;
            add_sub    = 1'b1;
            add_b      = acc_ff;
            if (contain && !area_zero) begin
               area_in  = acc_ff[W-1] ? add_sum[AW-1:0] : acc_ff[AW-1:0];
               qneg_in  = acc_ff[W-1];
               acc_in   = '0;
               k_in     = '0;
               phase_in = 1'b1;
               state_in = tel_pkg::S_LOAD;
            end else begin
               state_in = tel_pkg::S_FINISH;
            end
         end
         tel_pkg::S_NABS: begin
            add_zero_a = 1'b1;
            add_sub    = 1'b1;
            add_b      = acc_ff;
            acc_in     = acc_ff[W-1] ? add_sum : acc_ff;
            qneg_in    = qneg_ff ^ acc_ff[W-1];
            q_in       = '0;
            cnt_in     = CW'(N - 1);
            state_in   = tel_pkg::S_DIV;
         end
         tel_pkg::S_DIV: begin
            add_sub = 1'b1;
            add_b   = div_opnd;
            if (!add_sum[W-1]) begin
               acc_in = add_sum;
            end
            q_in   = q_fin;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               held_in  = qneg_ff ? (~q_fin + N'(1)) : q_fin;
               hit_in   = 1'b1;
               state_in = tel_pkg::S_FINISH;
            end
         end
         tel_pkg::S_FINISH: begin
            if (!last_ff) begin
               state_in = tel_pkg::S_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               found_in     = hit_ff;
               elev_in      = hit_ff ? held_ff : '0;
               hit_in       = 1'b0;
               held_in      = '0;
               state_in     = tel_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tel_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tel_pkg::S_IDLE;
         hit_ff       <= 1'b0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_ff       <= hit_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff <= qx_in; qy_ff <= qy_in;
      ax_ff <= ax_in; ay_ff <= ay_in; az_ff <= az_in;
      bx_ff <= bx_in; by_ff <= by_in; bz_ff <= bz_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      last_ff  <= last_in;
      acc_ff   <= acc_in;
      mc_ff    <= mc_in;
      mp_ff    <= mp_in;
      cnt_ff   <= cnt_in;
      k_ff     <= k_in;
      phase_ff <= phase_in;
      wa_ff    <= wa_in;
      wb_ff    <= wb_in;
      wc_ff    <= wc_in;
      area_ff  <= area_in;
      qneg_ff  <= qneg_in;
      q_ff     <= q_in;
      found_ff <= found_in;
      elev_ff  <= elev_in;
   end

   `TEL_ASSERT_NOW(a_miss_zero, clock, reset, rsp.valid && !rsp.found, rsp.elevation == '0)
   `TEL_ASSERT_NEXT(a_accept_busy, clock, reset, req.valid && req.ready, state_ff != tel_pkg::S_IDLE)
   `TEL_ASSERT_NOW(a_hit_from_div, clock, reset, $rose(hit_ff), $past(state_ff) == tel_pkg::S_DIV)
   `TEL_ASSERT_NOW(a_div_area, clock, reset, state_ff == tel_pkg::S_DIV, area_ff != '0)

endmodule
